@@ rtl/mkd_pkg.sv @@
package mkd_pkg;

    // Default depth of the message store, in bytes.
    localparam int MESSAGE_DEPTH_DEF = 16;

    // Number of event kinds, each with its own stored time stamp.
    localparam int KIND_COUNT = 4;

    // Field widths of the channels.
    localparam int KIND_W     = 2;
    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 16;
    localparam int RES_W      = 3;
    localparam int CHAR_W     = 8;
    localparam int MSG_LEN_W  = 4;
    localparam int CODE_LEN_W = 3;
    localparam int PATTERN_W  = 5;

    // Debounce delay after reset, in milliseconds.
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd150;

    // Mark counter limits: five marks at most, six flags an overflowed code.
    localparam logic [CODE_LEN_W-1:0] MAX_MARKS      = 3'd5;
    localparam logic [CODE_LEN_W-1:0] OVERFLOW_MARKS = 3'd6;

    // Event kinds.
    localparam logic [KIND_W-1:0] KIND_DOT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DASH  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ENTER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SEND  = 2'd3;

    // Result codes.
    localparam logic [RES_W-1:0] RES_MARK     = 3'd0;
    localparam logic [RES_W-1:0] RES_CHAR     = 3'd1;
    localparam logic [RES_W-1:0] RES_NO_MATCH = 3'd2;
    localparam logic [RES_W-1:0] RES_IGNORED  = 3'd3;
    localparam logic [RES_W-1:0] RES_SEND     = 3'd4;

    // One key event.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] time_ms;
        logic              record_active;
    } evt_item_t;

    // One result beat.
    typedef struct packed {
        logic [RES_W-1:0]      event_res;
        logic [CHAR_W-1:0]     character;
        logic [MSG_LEN_W-1:0]  message_length;
        logic [CODE_LEN_W-1:0] code_length;
        logic                  last;
    } res_item_t;

    // International Morse table. The key is the mark count followed by the
    // pattern, where bit i is mark i and a one stands for a dash. Codes that
    // are empty, overflowed or not in the table give zero.
    function automatic logic [CHAR_W-1:0] morse_char(
        input logic [CODE_LEN_W-1:0] count,
        input logic [PATTERN_W-1:0]  pattern
    );
        logic [CHAR_W-1:0] ch;
        ch = 8'h00;
        case ({count, pattern})
            {3'd2, 5'b00010}: ch = "A";
            {3'd4, 5'b00001}: ch = "B";
            {3'd4, 5'b00101}: ch = "C";
            {3'd3, 5'b00001}: ch = "D";
            {3'd1, 5'b00000}: ch = "E";
            {3'd4, 5'b00100}: ch = "F";
            {3'd3, 5'b00011}: ch = "G";
            {3'd4, 5'b00000}: ch = "H";
            {3'd2, 5'b00000}: ch = "I";
            {3'd4, 5'b01110}: ch = "J";
            {3'd3, 5'b00101}: ch = "K";
            {3'd4, 5'b00010}: ch = "L";
            {3'd2, 5'b00011}: ch = "M";
            {3'd2, 5'b00001}: ch = "N";
            {3'd3, 5'b00111}: ch = "O";
            {3'd4, 5'b00110}: ch = "P";
            {3'd4, 5'b01011}: ch = "Q";
            {3'd3, 5'b00010}: ch = "R";
            {3'd3, 5'b00000}: ch = "S";
            {3'd1, 5'b00001}: ch = "T";
            {3'd3, 5'b00100}: ch = "U";
            {3'd4, 5'b01000}: ch = "V";
            {3'd3, 5'b00110}: ch = "W";
            {3'd4, 5'b01001}: ch = "X";
            {3'd4, 5'b01101}: ch = "Y";
            {3'd4, 5'b00011}: ch = "Z";
            {3'd5, 5'b11110}: ch = "1";
            {3'd5, 5'b11100}: ch = "2";
            {3'd5, 5'b11000}: ch = "3";
            {3'd5, 5'b10000}: ch = "4";
            {3'd5, 5'b00000}: ch = "5";
            {3'd5, 5'b00001}: ch = "6";
            {3'd5, 5'b00011}: ch = "7";
            {3'd5, 5'b00111}: ch = "8";
            {3'd5, 5'b01111}: ch = "9";
            {3'd5, 5'b11111}: ch = "0";
            default:          ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/mkd_stream_if.sv @@
interface mkd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/mkd_ram.sv @@
module mkd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port; a read in the same cycle as a
    // write to the same entry returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/morse_key_decoder.sv @@
// Morse key decoder.
//
// Key events (dot, dash, enter, send with a millisecond time stamp) arrive as
// beats on the evt channel; results leave as beats on the res channel. Each
// kind keeps its last time stamp in a four-entry time RAM; an event counts
// only when record mode is off and at least debounce_ms have passed since the
// previous event of its kind. Dots and dashes build a code, enter decodes it
// into the message RAM, send plays the message out as MESSAGE_DEPTH bytes.
//
// An event is accepted in the idle state; its time stamp is read and checked
// in the cycle after, in the evaluate state, and the single result beat of a
// dot, dash or enter is registered when that state ends, once the output
// register is free. A send then streams one message byte per cycle out of the
// message RAM while the receiver keeps up. Both RAMs have a registered read.
// The block takes one event at a time; a new event is accepted while the last
// result beat still waits in the output register.
// Reset clears the code, the message length and the stored time stamps and
// loads the debounce delay with 150 ms. When the receiver stalls, the output
// register holds its beat and the block waits with it.
module morse_key_decoder
    import mkd_pkg::*;
#(
    parameter int MESSAGE_DEPTH = MESSAGE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [DEBOUNCE_W-1:0] cfg_data,
    mkd_stream_if.sink            evt,
    mkd_stream_if.source          res
);

    localparam int IDX_W = $clog2(MESSAGE_DEPTH);
    localparam int KIDX_W = $clog2(KIND_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MESSAGE_DEPTH - 1);
    localparam logic [IDX_W-1:0] FULL_CNT  = IDX_W'(MESSAGE_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [DEBOUNCE_W-1:0]   debounce_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic [TIME_W-1:0]       time_reg;
    logic                    rec_reg;
    logic [KIND_COUNT-1:0]   tvalid_reg, tvalid_next;
    logic [PATTERN_W-1:0]    pat_reg, pat_next;
    logic [CODE_LEN_W-1:0]   mcnt_reg, mcnt_next;
    logic [IDX_W-1:0]        msg_cnt_reg, msg_cnt_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    out_valid_reg;
    res_item_t               out_reg, out_next;
    logic                    out_load;

    logic                    accept;
    logic                    load;
    logic [TIME_W-1:0]       t_rdata;
    logic [TIME_W-1:0]       last_time;
    logic                    pass;
    logic                    t_we;
    logic [KIDX_W-1:0]       t_raddr;
    logic [CHAR_W-1:0]       m_rdata;
    logic                    m_we;
    logic [IDX_W-1:0]        m_raddr;
    logic [CHAR_W-1:0]       lookup_ch;
    logic [IDX_W+MSG_LEN_W-1:0] msg_len_ext;

    assign accept   = evt.valid && evt.ready;
    assign evt.ready = (state_reg == ST_IDLE);
    assign load     = !out_valid_reg || res.ready;
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    // Per-kind time stamps; read with the incoming kind, held while waiting.
    assign t_raddr = (state_reg == ST_IDLE) ? KIDX_W'(evt.data.kind) : KIDX_W'(kind_reg);

    mkd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (KIND_COUNT)
    ) u_time_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (KIDX_W'(kind_reg)),
        .wdata (time_reg),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    // Message bytes; during a send the next address is fetched as each byte leaves.
    always_comb
    begin
        if (state_reg == ST_SEND)
        begin
            m_raddr = load ? idx_reg + 1'b1 : idx_reg;
        end
        else
        begin
            m_raddr = '0;
        end
    end

    mkd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MESSAGE_DEPTH)
    ) u_msg_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (msg_cnt_reg),
        .wdata (lookup_ch),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    // Debounce check against the stored time of this kind.
    assign last_time = tvalid_reg[KIDX_W'(kind_reg)] ? t_rdata : '0;
    assign pass      = ((time_reg - last_time) >= TIME_W'(debounce_reg)) && !rec_reg;
    assign lookup_ch = morse_char(mcnt_reg, pat_reg);
    assign msg_len_ext = {{MSG_LEN_W{1'b0}}, msg_cnt_next};

    // Event evaluation and send sequencing.
    always_comb
    begin
        state_next   = state_reg;
        tvalid_next  = tvalid_reg;
        pat_next     = pat_reg;
        mcnt_next    = mcnt_reg;
        msg_cnt_next = msg_cnt_reg;
        idx_next     = idx_reg;
        t_we         = 1'b0;
        m_we         = 1'b0;
        out_load     = 1'b0;
        out_next     = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (load)
                begin
                    t_we = 1'b1;
                    tvalid_next[KIDX_W'(kind_reg)] = 1'b1;
                    state_next = ST_IDLE;
                    out_load   = 1'b1;
                    out_next.character = '0;
                    out_next.last      = 1'b1;
                    if (!pass)
                    begin
                        out_next.event_res = RES_IGNORED;
                    end
                    else if (kind_reg == KIND_DOT || kind_reg == KIND_DASH)
                    begin
                        if (mcnt_reg < MAX_MARKS)
                        begin
                            if (kind_reg == KIND_DASH)
                            begin
                                pat_next[mcnt_reg] = 1'b1;
                            end
                            mcnt_next = mcnt_reg + 1'b1;
                        end
                        else
                        begin
                            mcnt_next = OVERFLOW_MARKS;
                        end
                        out_next.event_res = RES_MARK;
                    end
                    else if (kind_reg == KIND_ENTER)
                    begin
                        pat_next  = '0;
                        mcnt_next = '0;
                        if (lookup_ch != 8'h00)
                        begin
                            if (msg_cnt_reg < FULL_CNT)
                            begin
                                m_we         = 1'b1;
                                msg_cnt_next = msg_cnt_reg + 1'b1;
                            end
                            out_next.event_res = RES_CHAR;
                            out_next.character = lookup_ch;
                        end
                        else
                        begin
                            out_next.event_res = RES_NO_MATCH;
                        end
                    end
                    else
                    begin
                        // Send: the bytes follow from the message RAM.
                        pat_next   = '0;
                        mcnt_next  = '0;
                        idx_next   = '0;
                        out_load   = 1'b0;
                        state_next = ST_SEND;
                    end
                    out_next.message_length = msg_len_ext[MSG_LEN_W-1:0];
                    out_next.code_length    = mcnt_next;
                end
            end
            ST_SEND:
            begin
                if (load)
                begin
                    out_load = 1'b1;
                    out_next.event_res      = RES_SEND;
                    out_next.character      = (idx_reg < msg_cnt_reg) ? m_rdata : '0;
                    out_next.message_length = '0;
                    out_next.code_length    = '0;
                    out_next.last           = (idx_reg == LAST_IDX);
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        msg_cnt_next = '0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and the debounce register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            debounce_reg  <= DEBOUNCE_RESET;
            tvalid_reg    <= '0;
            pat_reg       <= '0;
            mcnt_reg      <= '0;
            msg_cnt_reg   <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tvalid_reg  <= tvalid_next;
            pat_reg     <= pat_next;
            mcnt_reg    <= mcnt_next;
            msg_cnt_reg <= msg_cnt_next;
            idx_reg     <= idx_next;
            if (cfg_we)
            begin
                debounce_reg <= cfg_data;
            end
            if (load)
            begin
                out_valid_reg <= out_load;
            end
        end
    end

    // Captured event and output beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= evt.data.kind;
            time_reg <= evt.data.time_ms;
            rec_reg  <= evt.data.record_active;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

endmodule

@@ bench/morse_key_decoder_tb.sv @@
module morse_key_decoder_tb;

    import mkd_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 9;
    localparam int MSG_DEPTH    = MESSAGE_DEPTH_DEF;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_GAP   = 8;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_ITEMS  = 70;

    // One row of the directed stimulus; the expected beat is used only when typed is set.
    typedef struct {
        evt_item_t ev;
        bit        typed;
        res_item_t want;
    } key_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [DEBOUNCE_W-1:0] cfg_data;

    mkd_stream_if #(.T(evt_item_t)) evt_if ();
    mkd_stream_if #(.T(res_item_t)) res_if ();

    morse_key_decoder #(
        .MESSAGE_DEPTH(MSG_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .evt      (evt_if),
        .res      (res_if)
    );

    // Decoder state as the bench believes it to be.
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic [TIME_W-1:0]     last_ms [KIND_COUNT];
    logic [PATTERN_W-1:0]  code_marks;
    logic [CODE_LEN_W-1:0] code_len;
    logic [CHAR_W-1:0]     msg_bytes [MSG_DEPTH];
    logic [MSG_LEN_W-1:0]  msg_len;

    res_item_t expected_beats [$];
    key_row_t  key_rows [$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    int        send_idle_pct;
    int        recv_stall_pct;

    // International Morse codes, letters then digits, in the order of the characters below.
    string morse_codes [36] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
        ".----", "..---", "...--", "....-", ".....", "-....", "--...",
        "---..", "----.", "-----"
    };
    string morse_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890";

    always #(HALF_PERIOD) clk = ~clk;

    // Returns the character for a held code, or zero when the code is empty,
    // overflowed or not in the table.
    function automatic logic [CHAR_W-1:0] morse_lookup(input logic [CODE_LEN_W-1:0] len,
                                                       input logic [PATTERN_W-1:0] marks);
        bit hit;
        if (len == 0 || len > MAX_MARKS)
            return 8'h00;
        for (int e = 0; e < 36; e++)
        begin
            if (morse_codes[e].len() == len)
            begin
                hit = 1'b1;
                for (int i = 0; i < len; i++)
                    if ((morse_codes[e][i] == "-") != marks[i])
                        hit = 1'b0;
                if (hit)
                    return morse_chars[e];
            end
        end
        return 8'h00;
    endfunction

    // Queues one expected beat carrying the lengths held at this moment.
    function automatic void push_beat(input logic [RES_W-1:0] res, input logic [CHAR_W-1:0] ch,
                                      input logic last_beat);
        res_item_t b;
        b.event_res      = res;
        b.character      = ch;
        b.message_length = msg_len;
        b.code_length    = code_len;
        b.last           = last_beat;
        expected_beats.push_back(b);
    endfunction

    // Works out the beats that one key event causes and advances the state.
    // Returns whether the event got past the debounce and record checks.
    function automatic bit decode_key_event(input evt_item_t ev);
        logic [TIME_W-1:0] gap;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] snapshot [MSG_DEPTH];
        bit                taken;
        gap   = ev.time_ms - last_ms[ev.kind];
        taken = (gap >= TIME_W'(debounce_ms)) && !ev.record_active;
        last_ms[ev.kind] = ev.time_ms;
        if (!taken)
        begin
            push_beat(RES_IGNORED, 8'h00, 1'b1);
            return 1'b0;
        end
        if (ev.kind == KIND_DOT || ev.kind == KIND_DASH)
        begin
            // A sixth mark or later only flags the code as overflowed.
            if (code_len < MAX_MARKS)
            begin
                if (ev.kind == KIND_DASH)
                    code_marks[code_len] = 1'b1;
                code_len = code_len + 1'b1;
            end
            else
                code_len = OVERFLOW_MARKS;
            push_beat(RES_MARK, 8'h00, 1'b1);
        end
        else if (ev.kind == KIND_ENTER)
        begin
            ch         = morse_lookup(code_len, code_marks);
            code_marks = '0;
            code_len   = '0;
            if (ch != 8'h00)
            begin
                // A full message still reports the character but drops it.
                if (msg_len < MSG_DEPTH - 1)
                begin
                    msg_bytes[msg_len] = ch;
                    msg_len            = msg_len + 1'b1;
                end
                push_beat(RES_CHAR, ch, 1'b1);
            end
            else
                push_beat(RES_NO_MATCH, 8'h00, 1'b1);
        end
        else
        begin
            // Send plays out the whole store, zero padded, then clears the message and the code.
            for (int i = 0; i < MSG_DEPTH; i++)
                snapshot[i] = (i < msg_len) ? msg_bytes[i] : 8'h00;
            msg_len    = '0;
            code_marks = '0;
            code_len   = '0;
            for (int i = 0; i < MSG_DEPTH; i++)
                push_beat(RES_SEND, snapshot[i], i == MSG_DEPTH - 1);
        end
        return 1'b1;
    endfunction

    function automatic key_row_t key_row(input logic [KIND_W-1:0] kind,
                                         input logic [TIME_W-1:0] t, input logic rec,
                                         input bit typed, input logic [RES_W-1:0] res,
                                         input logic [CHAR_W-1:0] ch,
                                         input logic [MSG_LEN_W-1:0] mlen,
                                         input logic [CODE_LEN_W-1:0] clen);
        key_row_t r;
        r.ev.kind                = kind;
        r.ev.time_ms             = t;
        r.ev.record_active       = rec;
        r.typed                  = typed;
        r.want.event_res         = res;
        r.want.character         = ch;
        r.want.message_length    = mlen;
        r.want.code_length       = clen;
        r.want.last              = 1'b1;
        return r;
    endfunction

    // Picks a time stamp: mostly one that clears the debounce, some that fall
    // inside it, and a few anywhere in the 32-bit range.
    function automatic evt_item_t random_event(input logic [KIND_W-1:0] kind);
        evt_item_t ev;
        int        pick;
        pick             = $urandom_range(99);
        ev.kind          = kind;
        ev.record_active = ($urandom_range(24) == 0);
        if (pick < 80)
            ev.time_ms = last_ms[kind] + debounce_ms + $urandom_range(400);
        else if (pick < 93 && debounce_ms != 0)
            ev.time_ms = last_ms[kind] + $urandom_range(int'(debounce_ms) - 1);
        else
            ev.time_ms = $urandom;
        return ev;
    endfunction

    // Offers one event beat, with random idle cycles in front, and predicts it once taken.
    task automatic send_key_event(input evt_item_t ev, output bit taken);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            evt_if.valid <= 1'b0;
            @(negedge clk);
        end
        evt_if.valid <= 1'b1;
        evt_if.data  <= ev;
        @(posedge clk);
        while (!evt_if.ready)
            @(posedge clk);
        taken = decode_key_event(ev);
    endtask

    // Writes the debounce delay once the decoder has delivered everything.
    task automatic write_debounce(input logic [DEBOUNCE_W-1:0] value);
        @(negedge clk);
        evt_if.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we      <= 1'b0;
        debounce_ms = value;
    endtask

    // Mostly whole codes followed by enter, some broken codes, now and then a send.
    task automatic run_random(input int goal);
        int done_count;
        int e;
        int marks;
        bit taken;
        done_count = 0;
        while (done_count < goal)
        begin
            if ($urandom_range(23) == 0)
            begin
                send_key_event(random_event(KIND_SEND), taken);
                done_count++;
            end
            else
            begin
                if ($urandom_range(99) < 85)
                begin
                    e = $urandom_range(35);
                    for (int i = 0; i < morse_codes[e].len(); i++)
                    begin
                        send_key_event(random_event(morse_codes[e][i] == "-" ? KIND_DASH
                                                                             : KIND_DOT), taken);
                        done_count++;
                    end
                end
                else
                begin
                    marks = $urandom_range(7);
                    for (int i = 0; i < marks; i++)
                    begin
                        send_key_event(random_event($urandom_range(1) ? KIND_DASH : KIND_DOT),
                                       taken);
                        done_count++;
                    end
                end
                send_key_event(random_event(KIND_ENTER), taken);
                done_count++;
            end
        end
    endtask

    // Receiver: random back-pressure, changed on the falling edge.
    always @(negedge clk)
        res_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    // Each result beat is compared with the oldest expectation.
    always @(posedge clk)
    begin : check_beat
        res_item_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $write("unexpected result beat: res=%0d char=%02h ",
                           res_if.data.event_res, res_if.data.character);
                    $display("msg_len=%0d code_len=%0d last=%0b",
                             res_if.data.message_length, res_if.data.code_length,
                             res_if.data.last);
                end
            end
            else
            begin
                want = expected_beats.pop_front();
                if (res_if.data.event_res !== want.event_res ||
                    res_if.data.character !== want.character ||
                    res_if.data.message_length !== want.message_length ||
                    res_if.data.code_length !== want.code_length ||
                    res_if.data.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $write("result beat mismatch: expected res=%0d char=%02h msg_len=%0d ",
                               want.event_res, want.character, want.message_length);
                        $write("code_len=%0d last=%0b, got res=%0d char=%02h msg_len=%0d ",
                               want.code_length, want.last,
                               res_if.data.event_res, res_if.data.character,
                               res_if.data.message_length);
                        $display("code_len=%0d last=%0b",
                                 res_if.data.code_length, res_if.data.last);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any beat on either channel ends the run.
    always @(posedge clk)
    begin
        if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("morse_key_decoder test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        bit taken;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        evt_if.valid = 1'b0;
        evt_if.data  = '0;
        res_if.ready = 1'b0;

        // State after reset.
        debounce_ms = DEBOUNCE_RESET;
        code_marks  = '0;
        code_len    = '0;
        msg_len     = '0;
        foreach (last_ms[k])
            last_ms[k] = '0;

        send_idle_pct  = 18;
        recv_stall_pct = 69;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows: debounce edges, record mode, overflow, empty and
        // unmatched codes, sends, and time stamps around the wrap.
        key_rows.push_back(key_row(KIND_DOT, 32'd100, 1'b0, 1'b1, RES_IGNORED, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_DOT, 32'd250, 1'b0, 1'b1, RES_MARK, 8'h00, 4'd0, 3'd1));
        key_rows.push_back(key_row(KIND_ENTER, 32'd149, 1'b0, 1'b1, RES_IGNORED, 8'h00, 4'd0, 3'd1));
        key_rows.push_back(key_row(KIND_ENTER, 32'd1000, 1'b0, 1'b1, RES_CHAR, "E", 4'd1, 3'd0));
        key_rows.push_back(key_row(KIND_ENTER, 32'd1150, 1'b0, 1'b1, RES_NO_MATCH, 8'h00, 4'd1, 3'd0));
        key_rows.push_back(key_row(KIND_DASH, 32'd2000, 1'b1, 1'b1, RES_IGNORED, 8'h00, 4'd1, 3'd0));
        key_rows.push_back(key_row(KIND_DASH, 32'd2100, 1'b0, 1'b1, RES_IGNORED, 8'h00, 4'd1, 3'd0));
        key_rows.push_back(key_row(KIND_DASH, 32'd2250, 1'b0, 1'b1, RES_MARK, 8'h00, 4'd1, 3'd1));
        key_rows.push_back(key_row(KIND_DOT, 32'd3000, 1'b0, 1'b0, RES_MARK, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_DASH, 32'd4000, 1'b0, 1'b0, RES_MARK, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_DOT, 32'd5000, 1'b0, 1'b0, RES_MARK, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_DASH, 32'd6000, 1'b0, 1'b0, RES_MARK, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_DOT, 32'd7000, 1'b0, 1'b1, RES_MARK, 8'h00, 4'd1, 3'd6));
        key_rows.push_back(key_row(KIND_ENTER, 32'd8000, 1'b0, 1'b1, RES_NO_MATCH, 8'h00, 4'd1, 3'd0));
        key_rows.push_back(key_row(KIND_SEND, 32'd9000, 1'b0, 1'b0, RES_SEND, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_DASH, 32'hFFFF_FFFF, 1'b0, 1'b0, RES_MARK, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_DASH, 32'h0000_0095, 1'b0, 1'b0, RES_MARK, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_ENTER, 32'hFFFF_FF00, 1'b0, 1'b0, RES_MARK, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_DOT, 32'h8000_0000, 1'b0, 1'b0, RES_MARK, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_ENTER, 32'h0000_0000, 1'b0, 1'b0, RES_MARK, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_SEND, 32'hFFFF_FFFE, 1'b0, 1'b0, RES_SEND, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_SEND, 32'hFFFF_FFFF, 1'b0, 1'b1, RES_IGNORED, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_SEND, 32'h0000_00A0, 1'b1, 1'b1, RES_IGNORED, 8'h00, 4'd0, 3'd0));
        key_rows.push_back(key_row(KIND_DOT, 32'h7FFF_FFFF, 1'b0, 1'b0, RES_MARK, 8'h00, 4'd0, 3'd0));

        foreach (key_rows[r])
        begin
            send_key_event(key_rows[r].ev, taken);
            // A typed row replaces the single predicted beat with the one written above.
            if (key_rows[r].typed)
            begin
                void'(expected_beats.pop_back());
                expected_beats.push_back(key_rows[r].want);
            end
        end

        // Random phases across debounce settings, the extremes among them.
        write_debounce(16'd0);
        run_random(PHASE_ITEMS);
        write_debounce(16'hFFFF);
        run_random(PHASE_ITEMS);

        send_idle_pct  = 69;
        recv_stall_pct = 18;
        write_debounce(16'd40);
        run_random(PHASE_ITEMS);
        write_debounce(16'($urandom));
        run_random(PHASE_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_debounce(DEBOUNCE_RESET);
        run_random(PHASE_ITEMS);

        // Drain the decoder, then give it time to show any stray beat.
        @(negedge clk);
        evt_if.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("morse_key_decoder test passed");
        else
            $display("morse_key_decoder test failed");
        $finish;
    end

endmodule
